// ===== design/tmcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared constants, types and cursor helper for the text markup cell writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam logic [7:0] COLS = 8'd20;
  localparam logic [7:0] ROWS = 8'd10;

  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [1:0] REG_NORMAL  = 2'd0;
  localparam logic [1:0] REG_SPECIAL = 2'd1;
  localparam logic [1:0] REG_BG      = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic        last;
    logic [15:0] bg;
    logic [15:0] fg;
    logic [7:0]  ch;
    logic [5:0]  row;
    logic [5:0]  col;
  } cell_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
  } pos_t;

  typedef struct packed {
    logic [1:0] n;
    cell_t      c0;
    cell_t      c1;
    pos_t       cur;
    logic       spec;
    logic       pend;
  } step_t;

  // one cell right, wrap column then row
  function automatic pos_t adv(input pos_t p);
    pos_t r;
    if ((p.col + 8'd1) >= COLS) begin
      r.col = 8'd0;
      r.row = p.row + 8'd1;
    end else begin
      r.col = p.col + 8'd1;
      r.row = p.row;
    end
    if (r.row >= ROWS) r.row = 8'd0;
    return r;
  endfunction

endpackage

// ===== design/tmcw_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_step
// Decodes one byte against the cursor and markup state: up to two cells and
// the next state.
// ----------------------------------------------------------------------------
module tmcw_step (
  input  tmcw_pkg::pos_t  cur,
  input  logic            spec,
  input  logic            pend,
  input  logic            first_byte,
  input  logic [7:0]      start_col,
  input  logic [7:0]      start_row,
  input  logic [7:0]      char_byte,
  input  logic            final_byte,
  input  logic [15:0]     normal_text_color,
  input  logic [15:0]     special_text_color,
  input  logic [15:0]     background_color,
  output tmcw_pkg::step_t res
);

  tmcw_pkg::pos_t p0, p1, p2;
  logic spec0, pend0;
  logic is_open, is_close, is_bsl, is_crlf, bracket;
  logic esc_emit, plain, plain_emit, pend_after, flush, inr;
  logic [1:0] cnt;
  logic [7:0] ch0, ch1;
  logic [15:0] fg;

  always_comb begin
    if (first_byte) begin
      p0.col = start_col;
      p0.row = start_row;
      spec0  = 1'b0;
      pend0  = 1'b0;
    end else begin
      p0    = cur;
      spec0 = spec;
      pend0 = pend;
    end
    p1 = tmcw_pkg::adv(p0);
    p2 = tmcw_pkg::adv(p1);

    is_open  = (char_byte == tmcw_pkg::CH_OPEN);
    is_close = (char_byte == tmcw_pkg::CH_CLOSE);
    is_bsl   = (char_byte == tmcw_pkg::CH_BSL);
    is_crlf  = (char_byte == tmcw_pkg::CH_CR) || (char_byte == tmcw_pkg::CH_LF);
    bracket  = is_open || is_close;

    esc_emit   = pend0;
    plain      = !(pend0 && bracket);
    plain_emit = plain && !bracket && !is_crlf && !is_bsl;
    pend_after = plain && is_bsl;
    flush      = final_byte && pend_after;
    inr        = (p0.col < tmcw_pkg::COLS) && (p0.row < tmcw_pkg::ROWS);

    cnt = {1'b0, esc_emit} + {1'b0, plain_emit} + {1'b0, flush};
    if (!inr) cnt = 2'd0;

    // escaped bracket keeps its byte, otherwise a held backslash comes out
    if (esc_emit) ch0 = bracket ? char_byte : tmcw_pkg::CH_BSL;
    else if (plain_emit) ch0 = char_byte;
    else ch0 = tmcw_pkg::CH_BSL;
    ch1 = (esc_emit && plain_emit) ? char_byte : tmcw_pkg::CH_BSL;

    fg = spec0 ? special_text_color : normal_text_color;

    res.n       = cnt;
    res.c0.col  = p0.col[5:0];
    res.c0.row  = p0.row[5:0];
    res.c0.ch   = ch0;
    res.c0.fg   = fg;
    res.c0.bg   = background_color;
    res.c0.last = (cnt == 2'd1);
    res.c1.col  = p1.col[5:0];
    res.c1.row  = p1.row[5:0];
    res.c1.ch   = ch1;
    res.c1.fg   = fg;
    res.c1.bg   = background_color;
    res.c1.last = 1'b1;

    case (cnt)
      2'd1:    res.cur = p1;
      2'd2:    res.cur = p2;
      default: res.cur = p0;
    endcase

    if (plain && is_open) res.spec = 1'b1;
    else if (plain && is_close) res.spec = 1'b0;
    else res.spec = spec0;
    res.pend = pend_after && !flush;
  end

endmodule

// ===== design/text_markup_cell_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_markup_cell_writer
// Turns a string, one byte per item, into colored character cell writes.
// ----------------------------------------------------------------------------
// An item is registered, decoded combinationally and its cells (zero, one or
// two) pushed into a four-entry result queue, from which one cell leaves per
// cycle while m_tready is high. A new item is taken every cycle as long as the
// queue has room for two cells, so while m_tready is high items that make at
// most one cell stream at one item per cycle, while items that make two are
// held back by the single result port. A cell reaches m_tvalid after its item
// has passed the input register and been written into the result queue.
// Configuration takes effect on the next item; cfg_ready is always high.
// ----------------------------------------------------------------------------
module text_markup_cell_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // start_col, start_row, char_byte
  input  logic [0:0]  s_tuser,   // first_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // cell_col, cell_row, cell_char, cell_fg, cell_bg, zero pad
  output logic        m_tlast,   // run_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        in_v;
  logic [23:0] in_data;
  logic        in_first;
  logic        in_final;

  tmcw_pkg::pos_t cur;
  logic           spec;
  logic           pend;

  logic [15:0] normal_text_color;
  logic [15:0] special_text_color;
  logic [15:0] background_color;

  tmcw_pkg::cell_t q [tmcw_pkg::QDEPTH];
  tmcw_pkg::cell_t q_next [tmcw_pkg::QDEPTH];
  logic [tmcw_pkg::QCW-1:0] cnt, cnt_mid, cnt_next;

  tmcw_pkg::step_t res;
  logic fire, pop, push0, push1;

  tmcw_step u_step (
    .cur                (cur),
    .spec               (spec),
    .pend               (pend),
    .first_byte         (in_first),
    .start_col          (in_data[7:0]),
    .start_row          (in_data[15:8]),
    .char_byte          (in_data[23:16]),
    .final_byte         (in_final),
    .normal_text_color  (normal_text_color),
    .special_text_color (special_text_color),
    .background_color   (background_color),
    .res                (res)
  );

  assign cfg_ready = 1'b1;
  assign fire      = in_v && (cnt <= tmcw_pkg::QCW'(tmcw_pkg::QDEPTH - 2));
  assign s_tready  = !in_v || fire;
  assign pop       = (cnt != '0) && m_tready;
  assign push0     = fire && (res.n != 2'd0);
  assign push1     = fire && (res.n == 2'd2);
  assign cnt_mid   = cnt - tmcw_pkg::QCW'(pop);
  assign cnt_next  = cnt_mid + tmcw_pkg::QCW'(push0) + tmcw_pkg::QCW'(push1);

  assign m_tvalid = (cnt != '0);
  assign m_tdata  = {4'b0000, q[0].bg, q[0].fg, q[0].ch, q[0].row, q[0].col};
  assign m_tlast  = q[0].last;

  always_comb begin
    for (int i = 0; i < tmcw_pkg::QDEPTH; i++) begin
      if (push0 && (cnt_mid == tmcw_pkg::QCW'(i))) begin
        q_next[i] = res.c0;
      end else if (push1 && (cnt_mid + tmcw_pkg::QCW'(1) == tmcw_pkg::QCW'(i))) begin
        q_next[i] = res.c1;
      end else if (pop && (i < tmcw_pkg::QDEPTH - 1)) begin
        q_next[i] = q[(i < tmcw_pkg::QDEPTH - 1) ? i + 1 : i];
      end else begin
        q_next[i] = q[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < tmcw_pkg::QDEPTH; i++) q[i] <= q_next[i];
    if (s_tvalid && s_tready) begin
      in_data  <= s_tdata;
      in_first <= s_tuser[0];
      in_final <= s_tlast;
    end
    if (rst) begin
      in_v               <= 1'b0;
      cnt                <= '0;
      cur                <= '0;
      spec               <= 1'b0;
      pend               <= 1'b0;
      normal_text_color  <= '0;
      special_text_color <= '0;
      background_color   <= '0;
    end else begin
      if (s_tready) in_v <= s_tvalid;
      cnt <= cnt_next;
      if (fire) begin
        cur  <= res.cur;
        spec <= res.spec;
        pend <= res.pend;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tmcw_pkg::REG_NORMAL:  normal_text_color  <= cfg_data;
          tmcw_pkg::REG_SPECIAL: special_text_color <= cfg_data;
          tmcw_pkg::REG_BG:      background_color   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== design/tmcw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_checker
// Port-level checks for the text markup cell writer, bound to the top level.
// ----------------------------------------------------------------------------
module tmcw_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tlast
);

  // stalled cell holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled cell changed");

  // cells land inside the screen
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({2'b00, m_tdata[5:0]} < tmcw_pkg::COLS)
              && ({2'b00, m_tdata[11:6]} < tmcw_pkg::ROWS))
    else $error("cell outside screen");

  // a non-last cell is followed at once by the last cell of its item
  a_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
    else $error("second cell of item missing");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind text_markup_cell_writer tmcw_checker u_tmcw_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== tb/text_markup_cell_writer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_markup_cell_writer_test
// Self-checking bench for the text markup cell writer. Strings are streamed
// in one byte per item. A cell tracker keeps the cursor, the bracket color
// mode, the held backslash and the color registers. It queues the cell writes
// that each accepted item must produce and checks every cell that comes out.
// A short directed part covers brackets, escapes, CR/LF, wrapping and
// off-screen starts. Random strings then follow over several color settings,
// with random idle gaps on the sending side and the receiving side.
// ----------------------------------------------------------------------------
module text_markup_cell_writer_test;

  class cell_tracker;
    logic [15:0] normal_fg;
    logic [15:0] special_fg;
    logic [15:0] back_color;
    logic [7:0]  cur_col;
    logic [7:0]  cur_row;
    bit          in_special;
    bit          bsl_held;
    tmcw_pkg::cell_t cells_due[$];
    tmcw_pkg::cell_t fresh[2];
    int          n_fresh;
    int          errors;
    int          items;
    int          cells;
    int          bracket_cells;
    int          escapes;

    function new();
      normal_fg = '0;
      special_fg = '0;
      back_color = '0;
      cur_col = '0;
      cur_row = '0;
      in_special = 0;
      bsl_held = 0;
      n_fresh = 0;
      errors = 0;
      items = 0;
      cells = 0;
      bracket_cells = 0;
      escapes = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        tmcw_pkg::REG_NORMAL: begin
          normal_fg = val;
        end
        tmcw_pkg::REG_SPECIAL: begin
          special_fg = val;
        end
        tmcw_pkg::REG_BG: begin
          back_color = val;
        end
        default: begin
        end
      endcase
    endfunction

    // off-screen cursor: no write, no move
    function void put_cell(logic [7:0] ch);
      tmcw_pkg::cell_t c;
      if (cur_col >= tmcw_pkg::COLS || cur_row >= tmcw_pkg::ROWS) return;
      c.col = cur_col[5:0];
      c.row = cur_row[5:0];
      c.ch = ch;
      c.fg = in_special ? special_fg : normal_fg;
      c.bg = back_color;
      c.last = 1'b0;
      if (in_special) bracket_cells++;
      fresh[n_fresh] = c;
      n_fresh++;
      if (int'(cur_col) + 1 >= int'(tmcw_pkg::COLS)) begin
        cur_col = '0;
        cur_row = cur_row + 8'd1;
      end else begin
        cur_col = cur_col + 8'd1;
      end
      if (cur_row >= tmcw_pkg::ROWS) cur_row = '0;
    endfunction

    function void take_byte(bit first, logic [7:0] scol, logic [7:0] srow,
                            logic [7:0] ch, bit fin);
      bit plain;
      int i;
      n_fresh = 0;
      plain = 1;
      items++;
      if (first) begin
        cur_col = scol;
        cur_row = srow;
        in_special = 0;
        bsl_held = 0;
      end
      if (bsl_held) begin
        bsl_held = 0;
        if (ch == tmcw_pkg::CH_OPEN || ch == tmcw_pkg::CH_CLOSE) begin
          put_cell(ch);
          plain = 0;
          escapes++;
        end else begin
          put_cell(tmcw_pkg::CH_BSL);
        end
      end
      if (plain) begin
        if (ch == tmcw_pkg::CH_OPEN) begin
          in_special = 1;
        end else if (ch == tmcw_pkg::CH_CLOSE) begin
          in_special = 0;
        end else if (ch == tmcw_pkg::CH_CR || ch == tmcw_pkg::CH_LF) begin
        end else if (ch == tmcw_pkg::CH_BSL) begin
          bsl_held = 1;
        end else begin
          put_cell(ch);
        end
      end
      if (fin && bsl_held) begin
        bsl_held = 0;
        put_cell(tmcw_pkg::CH_BSL);
      end
      for (i = 0; i < n_fresh; i++) begin
        fresh[i].last = (i == n_fresh - 1);
        cells_due.push_back(fresh[i]);
      end
    endfunction

    function void compare(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_cell(logic [55:0] data, logic last);
      tmcw_pkg::cell_t want;
      if (cells_due.size() == 0) begin
        $error("cell out with no cell due: tdata 0x%0h", data);
        errors++;
        return;
      end
      want = cells_due.pop_front();
      cells++;
      compare("cell_col", want.col, data[5:0]);
      compare("cell_row", want.row, data[11:6]);
      compare("cell_char", want.ch, data[19:12]);
      compare("cell_fg", want.fg, data[35:20]);
      compare("cell_bg", want.bg, data[51:36]);
      compare("run_last", want.last, last);
    endfunction

    function int pending();
      return cells_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // start_col, start_row, char_byte
  logic [0:0]  s_tuser;   // first_byte
  logic        s_tlast;   // final_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;   // cell_col, cell_row, cell_char, cell_fg, cell_bg, zero pad
  logic        m_tlast;   // run_last
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  cell_tracker tracker;
  bit          quiet;
  int          strings;
  int          settings;

  text_markup_cell_writer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("text_markup_cell_writer_test NOT OK");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int hold;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_cell(m_tdata, m_tlast);
  end

  task automatic send(bit first, logic [7:0] scol, logic [7:0] srow,
                      logic [7:0] ch, bit fin);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ch, srow, scol};
    s_tuser <= first;
    s_tlast <= fin;
    do @(posedge clk); while (!s_tready);
    tracker.take_byte(first, scol, srow, ch, fin);
  endtask

  // wait out every due cell plus the pipeline depth for cell-less items
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_colors(logic [15:0] nrm, logic [15:0] spc, logic [15:0] bgc);
    write_reg(tmcw_pkg::REG_NORMAL, nrm);
    write_reg(tmcw_pkg::REG_SPECIAL, spc);
    write_reg(tmcw_pkg::REG_BG, bgc);
    settings++;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return tmcw_pkg::CH_OPEN;
    if (r < 22) return tmcw_pkg::CH_CLOSE;
    if (r < 34) return tmcw_pkg::CH_BSL;
    if (r < 38) return tmcw_pkg::CH_CR;
    if (r < 42) return tmcw_pkg::CH_LF;
    if (r < 45) return 8'h00;
    if (r < 48) return 8'hFF;
    if (r < 52) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // mostly well-formed strings; some with random start and end marks
  task automatic send_string();
    int len;
    int i;
    bit noisy;
    bit first;
    bit fin;
    logic [7:0] scol;
    logic [7:0] srow;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
    noisy = ($urandom_range(0, 9) == 0);
    strings++;
    for (i = 0; i < len; i++) begin
      first = (i == 0);
      fin = (i == len - 1);
      if (noisy) begin
        first = $urandom_range(0, 1);
        fin = $urandom_range(0, 1);
      end
      scol = 8'($urandom_range(0, 255));
      srow = 8'($urandom_range(0, 255));
      if (i == 0 && $urandom_range(0, 99) < 85) begin
        scol = 8'($urandom_range(0, tmcw_pkg::COLS - 1));
        srow = 8'($urandom_range(0, tmcw_pkg::ROWS - 1));
      end
      send(first, scol, srow, pick_char(), fin);
    end
  endtask

  initial begin
    int p;
    int target;
    bit paused;
    tracker = new();
    quiet = 0;
    paused = 0;
    strings = 0;
    settings = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = tmcw_pkg::REG_NORMAL;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_colors(16'h1234, 16'hF800, 16'h001F);

    // byte before any string start, cursor from reset
    send(0, 8'd0, 8'd0, "A", 0);
    // last cell of the screen, wraps to the top left
    send(1, tmcw_pkg::COLS - 8'd1, tmcw_pkg::ROWS - 8'd1, 8'h00, 0);
    send(0, 8'd0, 8'd0, 8'hFF, 0);
    send(0, 8'd0, 8'd0, tmcw_pkg::CH_OPEN, 0);
    send(0, 8'd0, 8'd0, "x", 0);
    send(0, 8'd0, 8'd0, tmcw_pkg::CH_CLOSE, 0);
    send(0, 8'd0, 8'd0, "y", 1);
    // escaped brackets
    send(1, 8'd4, 8'd2, tmcw_pkg::CH_BSL, 0);
    send(0, 8'd0, 8'd0, tmcw_pkg::CH_OPEN, 0);
    send(0, 8'd0, 8'd0, tmcw_pkg::CH_BSL, 0);
    send(0, 8'd0, 8'd0, tmcw_pkg::CH_CLOSE, 0);
    // backslash before a plain byte gives two cells
    send(0, 8'd0, 8'd0, tmcw_pkg::CH_BSL, 0);
    send(0, 8'd0, 8'd0, "q", 0);
    // backslash before CR, then a lone LF
    send(0, 8'd0, 8'd0, tmcw_pkg::CH_BSL, 0);
    send(0, 8'd0, 8'd0, tmcw_pkg::CH_CR, 0);
    send(0, 8'd0, 8'd0, tmcw_pkg::CH_LF, 0);
    // held backslash flushed by the last byte
    send(0, 8'd0, 8'd0, tmcw_pkg::CH_BSL, 1);
    // held backslash dropped by a new string
    send(1, 8'd5, 8'd5, tmcw_pkg::CH_BSL, 0);
    send(1, 8'd0, 8'd0, "B", 0);
    // off-screen starts
    send(1, tmcw_pkg::COLS, 8'd0, "C", 0);
    send(0, 8'd0, 8'd0, tmcw_pkg::CH_OPEN, 0);
    send(0, 8'd0, 8'd0, "D", 0);
    send(1, 8'd3, tmcw_pkg::ROWS, "F", 0);
    send(0, 8'd0, 8'd0, tmcw_pkg::CH_BSL, 0);
    send(1, 8'hFF, 8'hFF, "E", 1);
    drain();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_colors(16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: set_colors(16'h0000, 16'h0000, 16'h0000);
        default: set_colors(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      quiet = (p == 3);
      target = tracker.items + 190;
      while (tracker.items < target) begin
        send_string();
        if (p == 4 && !paused && tracker.items > target - 100) begin
          paused = 1;
          @(negedge clk);
          s_tvalid <= 1'b0;
          while (tracker.pending() > 0) @(posedge clk);
        end
      end
      drain();
    end

    $display("ran %0d items in %0d strings over %0d color settings",
             tracker.items, strings, settings);
    $display("checked %0d cells, %0d in bracket color, %0d escaped brackets",
             tracker.cells, tracker.bracket_cells, tracker.escapes);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("text_markup_cell_writer_test OK");
    end else begin
      $display("text_markup_cell_writer_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== text_markup_cell_writer.f =====
design/tmcw_pkg.sv
design/tmcw_step.sv
design/text_markup_cell_writer.sv
design/tmcw_checker.sv
tb/text_markup_cell_writer_test.sv
